// File: hdl/kvl_pkg.sv
// ----------------------------------------------------------------------------
// kvl_pkg: shared types and constants for the keyframe interpolator
// Field widths, command and status codes, and the packed structs that carry
// three-component values and the signed blend factor between modules.
// ----------------------------------------------------------------------------
package kvl_pkg;

  // Fixed field widths of the item and result ports.
  localparam int TIME_W       = 32;
  localparam int VAL_W        = 32;
  localparam int FRAC_W       = 16;
  localparam int KEY_INDEX_W  = 6;
  localparam int COUNT_W      = 7;
  localparam int SEG_W        = 6;
  localparam int MAX_KEYS_DEF = 64;

  // Command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Status codes.
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_ZERO_SPAN = 1'b1;

  // One keyframe value, three signed Q16.16 components.
  typedef struct packed {
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
    logic signed [VAL_W-1:0] z;
  } vec3_t;

  // Saturated blend factor in sign and magnitude form.
  typedef struct packed {
    logic             neg;
    logic [VAL_W-1:0] mag;
  } factor_t;

endpackage

// File: hdl/kvl_key_store.sv
// ----------------------------------------------------------------------------
// kvl_key_store: keyframe time and value memories
// One write port and one read port shared by both arrays, with the read
// data registered.
// ----------------------------------------------------------------------------
module kvl_key_store #(
  parameter int MAX_KEYS = kvl_pkg::MAX_KEYS_DEF,
  localparam int AW = $clog2(MAX_KEYS)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [kvl_pkg::TIME_W-1:0] wr_time,
  input  kvl_pkg::vec3_t             wr_value,
  input  logic [AW-1:0]              rd_addr,
  output logic [kvl_pkg::TIME_W-1:0] rd_time,
  output kvl_pkg::vec3_t             rd_value
);

  logic [kvl_pkg::TIME_W-1:0] times [MAX_KEYS];
  kvl_pkg::vec3_t             values [MAX_KEYS];

  // Write one entry, read one entry per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      times[wr_addr]  <= wr_time;
      values[wr_addr] <= wr_value;
    end
    rd_time  <= times[rd_addr];
    rd_value <= values[rd_addr];
  end

endmodule

// File: hdl/kvl_divider.sv
// ----------------------------------------------------------------------------
// kvl_divider: iterative blend factor divider
// Computes (num * 2^16) / den truncated toward zero, one quotient bit per
// cycle, and saturates the result to the signed 32-bit range.
// ----------------------------------------------------------------------------
module kvl_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [kvl_pkg::VAL_W:0]  num,
  input  logic signed [kvl_pkg::VAL_W:0]  den,
  output logic                            done,
  output kvl_pkg::factor_t                factor
);

  localparam int W  = kvl_pkg::VAL_W;
  localparam int QW = kvl_pkg::VAL_W + kvl_pkg::FRAC_W;
  localparam int SW = $clog2(QW);

  typedef enum logic [3:0] {
    DV_IDLE = 4'b0001,
    DV_ABS  = 4'b0010,
    DV_RUN  = 4'b0100,
    DV_FIN  = 4'b1000
  } dv_state_t;

  dv_state_t          state;
  logic signed [W:0]  num_raw;
  logic signed [W:0]  den_raw;
  logic               quo_neg;
  logic [QW-1:0]      dvd;
  logic [W-1:0]       div_mag;
  logic [W-1:0]       rem;
  logic [SW-1:0]      step;

  logic [W:0]         num_abs;
  logic [W:0]         den_abs;
  logic [W:0]         trial;
  logic [W:0]         trial_sub;
  logic               trial_ge;
  logic [W-1:0]       limit;

  // Magnitudes, trial subtraction and saturation limit.
  always_comb begin
    num_abs   = num_raw[W] ? (-num_raw) : num_raw;
    den_abs   = den_raw[W] ? (-den_raw) : den_raw;
    trial     = {rem, dvd[QW-1]};
    trial_sub = trial - {1'b0, div_mag};
    trial_ge  = (trial >= {1'b0, div_mag});
    limit     = {1'b0, {(W-1){1'b1}}} + W'(quo_neg);
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        DV_IDLE: begin
          if (start) begin
            num_raw <= num;
            den_raw <= den;
            state   <= DV_ABS;
          end
        end
        DV_ABS: begin
          dvd     <= {num_abs[W-1:0], {kvl_pkg::FRAC_W{1'b0}}};
          div_mag <= den_abs[W-1:0];
          quo_neg <= num_raw[W] ^ den_raw[W];
          rem     <= '0;
          step    <= '0;
          state   <= DV_RUN;
        end
        DV_RUN: begin
          rem  <= trial_ge ? trial_sub[W-1:0] : trial[W-1:0];
          dvd  <= {dvd[QW-2:0], trial_ge};
          step <= step + SW'(1);
          if (step == SW'(QW - 1)) begin
            state <= DV_FIN;
          end
        end
        DV_FIN: begin
          factor.neg <= quo_neg;
          factor.mag <= (dvd > QW'(limit)) ? limit : dvd[W-1:0];
          done       <= 1'b1;
          state      <= DV_IDLE;
        end
        default: begin
          state <= DV_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/kvl_blend.sv
// ----------------------------------------------------------------------------
// kvl_blend: per-component blend of two keyframe values
// Works through x, y and z in turn: difference, one 32x32 product, floor
// shift by 16 and a saturating add to the start value.
// ----------------------------------------------------------------------------
module kvl_blend (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  kvl_pkg::factor_t factor,
  input  kvl_pkg::vec3_t   v_start,
  input  kvl_pkg::vec3_t   v_end,
  output logic             done,
  output kvl_pkg::vec3_t   result
);

  localparam int W  = kvl_pkg::VAL_W;
  localparam int FW = kvl_pkg::FRAC_W;
  localparam int PW = 2 * W;
  localparam int TW = PW + 1 - FW;

  typedef enum logic [4:0] {
    BL_IDLE  = 5'b00001,
    BL_DIFF  = 5'b00010,
    BL_MUL   = 5'b00100,
    BL_SHIFT = 5'b01000,
    BL_SUM   = 5'b10000
  } bl_state_t;

  bl_state_t               state;
  logic [1:0]              comp;
  logic signed [W-1:0]     cur_start;
  logic [W-1:0]            d_mag;
  logic                    prod_neg;
  logic [PW-1:0]           prod;
  logic signed [TW-1:0]    term;

  logic signed [W-1:0]     sel_start;
  logic signed [W-1:0]     sel_end;
  logic signed [W:0]       diff_fw;
  logic signed [W:0]       diff_bw;
  logic signed [PW:0]      p_signed;
  logic signed [TW:0]      sum;
  logic signed [W-1:0]     sum_sat;

  // Component select, difference, sign fold and saturation.
  always_comb begin
    case (comp)
      2'd0: begin
        sel_start = v_start.x;
        sel_end   = v_end.x;
      end
      2'd1: begin
        sel_start = v_start.y;
        sel_end   = v_end.y;
      end
      default: begin
        sel_start = v_start.z;
        sel_end   = v_end.z;
      end
    endcase
    diff_fw  = {sel_end[W-1], sel_end} - {sel_start[W-1], sel_start};
    diff_bw  = {sel_start[W-1], sel_start} - {sel_end[W-1], sel_end};
    p_signed = prod_neg ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
    sum      = {{(TW-W+1){cur_start[W-1]}}, cur_start} + {term[TW-1], term};
    if (sum > $signed((TW+1)'({1'b0, {(W-1){1'b1}}}))) begin
      sum_sat = {1'b0, {(W-1){1'b1}}};
    end else if (sum < -$signed((TW+1)'({1'b1, {(W-1){1'b0}}}))) begin
      sum_sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      sum_sat = sum[W-1:0];
    end
  end

  // Sequencer over the three components.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BL_IDLE;
      comp  <= 2'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        BL_IDLE: begin
          if (start) begin
            comp  <= 2'd0;
            state <= BL_DIFF;
          end
        end
        BL_DIFF: begin
          cur_start <= sel_start;
          d_mag     <= diff_fw[W] ? diff_bw[W-1:0] : diff_fw[W-1:0];
          prod_neg  <= factor.neg ^ diff_fw[W];
          state     <= BL_MUL;
        end
        BL_MUL: begin
          prod  <= factor.mag * d_mag;
          state <= BL_SHIFT;
        end
        BL_SHIFT: begin
          // Arithmetic shift by the fraction width rounds toward minus infinity.
          term  <= p_signed[PW:FW];
          state <= BL_SUM;
        end
        BL_SUM: begin
          case (comp)
            2'd0:    result.x <= sum_sat;
            2'd1:    result.y <= sum_sat;
            default: result.z <= sum_sat;
          endcase
          if (comp == 2'd2) begin
            done  <= 1'b1;
            state <= BL_IDLE;
          end else begin
            comp  <= comp + 2'd1;
            state <= BL_DIFF;
          end
        end
        default: begin
          state <= BL_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/keyframe_vector_lerp.sv
// ----------------------------------------------------------------------------
// keyframe_vector_lerp: keyframe table with linear interpolation
// Write items load keyframes; query items return the interpolated x, y, z.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A write item gives no
// result. A query scans the key times one per cycle from the key table's read
// port, then fetches the segment's two keys, runs the bit-serial divider (one
// quotient bit per cycle, 48 bits) and blends x, y and z in turn on one 32x32
// multiplier. A zero-length segment ends the query without the divider and
// the blend, and a single-key table returns its only key without a scan. Each
// result is shown for exactly one cycle with done high and cannot be held
// off, so the receiver must take it then. The user must write the key_count
// register through cfg_valid/cfg_ready only while no query is in flight; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module keyframe_vector_lerp #(
  parameter int MAX_KEYS = kvl_pkg::MAX_KEYS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  command,
  input  logic [kvl_pkg::KEY_INDEX_W-1:0]       key_index,
  input  logic [kvl_pkg::TIME_W-1:0]            key_time,
  input  logic signed [kvl_pkg::VAL_W-1:0]      key_x,
  input  logic signed [kvl_pkg::VAL_W-1:0]      key_y,
  input  logic signed [kvl_pkg::VAL_W-1:0]      key_z,
  input  logic [kvl_pkg::TIME_W-1:0]            query_time,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [kvl_pkg::COUNT_W-1:0]           cfg_data,
  output logic                                  done,
  output logic signed [kvl_pkg::VAL_W-1:0]      out_x,
  output logic signed [kvl_pkg::VAL_W-1:0]      out_y,
  output logic signed [kvl_pkg::VAL_W-1:0]      out_z,
  output logic [kvl_pkg::SEG_W-1:0]             segment,
  output logic                                  status
);

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int TW = kvl_pkg::TIME_W;
  localparam int W  = kvl_pkg::VAL_W;

  typedef enum logic [7:0] {
    ST_IDLE        = 8'b00000001,
    ST_SCAN        = 8'b00000010,
    ST_FETCH_START = 8'b00000100,
    ST_FETCH_END   = 8'b00001000,
    ST_LOAD_END    = 8'b00010000,
    ST_PREP        = 8'b00100000,
    ST_DIVIDE      = 8'b01000000,
    ST_BLEND       = 8'b10000000
  } kvl_state_t;

  kvl_state_t                  state;
  logic [kvl_pkg::COUNT_W-1:0] key_count;
  logic [CW-1:0]               key_num;
  logic [TW-1:0]               query;
  logic [AW-1:0]               scan_i;
  logic [AW-1:0]               seg;
  logic                        single;
  logic [TW-1:0]               t0;
  logic [TW-1:0]               t1;
  kvl_pkg::vec3_t              v0;
  kvl_pkg::vec3_t              v1;
  kvl_pkg::vec3_t              res;

  logic                        accept;
  logic                        wr_en;
  logic [AW-1:0]               rd_addr;
  logic [TW-1:0]               rd_time;
  kvl_pkg::vec3_t              rd_value;
  kvl_pkg::vec3_t              wr_value;
  logic [CW-1:0]               count_eff;
  logic                        scan_hit;
  logic                        scan_last;
  logic signed [W:0]           num;
  logic signed [W:0]           dt;
  logic                        dt_zero;
  logic                        div_start;
  logic                        div_done;
  kvl_pkg::factor_t            factor;
  logic                        blend_done;
  kvl_pkg::vec3_t              blend_res;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign wr_en     = accept && (command == kvl_pkg::CMD_WRITE) &&
                     (int'(key_index) < MAX_KEYS);
  assign wr_value  = '{x: key_x, y: key_y, z: key_z};

  assign out_x = res.x;
  assign out_y = res.y;
  assign out_z = res.z;

  // Effective key count, scan decisions and segment arithmetic.
  always_comb begin
    if (key_count == '0) begin
      count_eff = CW'(1);
    end else if (int'(key_count) > MAX_KEYS) begin
      count_eff = CW'(MAX_KEYS);
    end else begin
      count_eff = CW'(key_count);
    end
    scan_hit  = (query < rd_time);
    scan_last = ((CW'(scan_i) + CW'(2)) == key_num);
    num       = $signed({1'b0, query}) - $signed({1'b0, t0});
    dt        = $signed({1'b0, t1}) - $signed({1'b0, t0});
    dt_zero   = (dt == '0);
    div_start = (state == ST_PREP) && !dt_zero;
  end

  // Read address for the key table.
  always_comb begin
    case (state)
      ST_IDLE:        rd_addr = AW'(1);
      ST_SCAN:        rd_addr = scan_i + AW'(2);
      ST_FETCH_START: rd_addr = seg;
      ST_FETCH_END:   rd_addr = seg + AW'(1);
      default:        rd_addr = seg;
    endcase
  end

  // Key count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= kvl_pkg::COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      key_count <= cfg_data;
    end
  end

  // Query sequencer and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && (command == kvl_pkg::CMD_QUERY)) begin
            query   <= query_time;
            key_num <= count_eff;
            scan_i  <= '0;
            seg     <= '0;
            single  <= (count_eff == CW'(1));
            state   <= (count_eff == CW'(1)) ? ST_FETCH_START : ST_SCAN;
          end
        end
        ST_SCAN: begin
          // First segment whose end time lies beyond the query, else segment 0.
          if (scan_hit) begin
            seg   <= scan_i;
            state <= ST_FETCH_START;
          end else if (scan_last) begin
            seg   <= '0;
            state <= ST_FETCH_START;
          end else begin
            scan_i <= scan_i + AW'(1);
          end
        end
        ST_FETCH_START: begin
          state <= ST_FETCH_END;
        end
        ST_FETCH_END: begin
          t0 <= rd_time;
          v0 <= rd_value;
          if (single) begin
            res     <= rd_value;
            segment <= '0;
            status  <= kvl_pkg::STATUS_OK;
            done    <= 1'b1;
            state   <= ST_IDLE;
          end else begin
            state <= ST_LOAD_END;
          end
        end
        ST_LOAD_END: begin
          t1    <= rd_time;
          v1    <= rd_value;
          state <= ST_PREP;
        end
        ST_PREP: begin
          if (dt_zero) begin
            res     <= v0;
            segment <= kvl_pkg::SEG_W'(seg);
            status  <= kvl_pkg::STATUS_ZERO_SPAN;
            done    <= 1'b1;
            state   <= ST_IDLE;
          end else begin
            state <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            state <= ST_BLEND;
          end
        end
        ST_BLEND: begin
          if (blend_done) begin
            res     <= blend_res;
            segment <= kvl_pkg::SEG_W'(seg);
            status  <= kvl_pkg::STATUS_OK;
            done    <= 1'b1;
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  kvl_key_store #(
    .MAX_KEYS (MAX_KEYS)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (AW'(key_index)),
    .wr_time  (key_time),
    .wr_value (wr_value),
    .rd_addr  (rd_addr),
    .rd_time  (rd_time),
    .rd_value (rd_value)
  );

  kvl_divider u_divider (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (num),
    .den    (dt),
    .done   (div_done),
    .factor (factor)
  );

  kvl_blend u_blend (
    .clk     (clk),
    .rst     (rst),
    .start   (div_done),
    .factor  (factor),
    .v_start (v0),
    .v_end   (v1),
    .done    (blend_done),
    .result  (blend_res)
  );

  // The result strobe never lasts longer than one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // A query keeps the block busy after it is taken; a write does not.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (command == kvl_pkg::CMD_QUERY)) |=> busy)
    else $error("query accepted but block not busy");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && (command == kvl_pkg::CMD_WRITE)) |=> !busy)
    else $error("write item left the block busy");

  // The scan never looks past the last key in use.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ((CW'(scan_i) + CW'(2)) <= key_num))
    else $error("key scan ran past the key count");

  // The divider starts only on a nonzero span while preparing.
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> ((state == ST_PREP) && !dt_zero))
    else $error("divider started outside the prepare step");

endmodule
